### design/lbq_pkg.sv
// lbq_pkg: shared sizes, codes and control/status types for the linked buffer queue
// no dependencies; imported by lbq_ctrl, lbq_datapath and linked_buffer_queue
package lbq_pkg;

    localparam int NUM_BUFFERS = 64;
    localparam int ADDR_W      = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int LINK_W      = ADDR_W + 1;
    localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);
    localparam int ID_W        = 6;
    localparam int QLEN_W      = 7;

    // null link: top bit set
    localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {ADDR_W{1'b0}}};

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_REM = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_ABSENT = 2'd2,
        ST_DUP    = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [ID_W-1:0] buf_id;
    } lbq_req_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   out_id;
        logic [QLEN_W-1:0] queue_length;
    } lbq_rsp_t;

    typedef struct packed {
        logic    load;
        logic    capture;
        logic    enq_self;
        logic    enq_tail;
        logic    unlink;
        logic    respond;
        status_t status;
    } lbq_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic id_ok;
        logic queued;
        logic empty;
    } lbq_stat_t;

endpackage

### design/lbq_ctrl.sv
// lbq_ctrl: request sequencer for the linked buffer queue
// depends on lbq_pkg; drives lbq_datapath through lbq_ctrl_t
module lbq_ctrl
    import lbq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  lbq_stat_t stat,
    output lbq_ctrl_t ctrl,
    output logic      busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_ENQ_LINK,
        S_UNLINK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        ctrl       = '0;
        ctrl.status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctrl.capture = 1'b1;
                unique case (stat.cmd)
                    CMD_ENQ:
                    begin
                        if (!stat.id_ok)
                        begin
                            ctrl.respond = 1'b1;
                            ctrl.status  = ST_ABSENT;
                            state_next   = S_IDLE;
                        end
                        else if (stat.queued)
                        begin
                            ctrl.respond = 1'b1;
                            ctrl.status  = ST_DUP;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            ctrl.enq_self = 1'b1;
                            state_next    = S_ENQ_LINK;
                        end
                    end
                    CMD_DEQ:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.respond = 1'b1;
                            ctrl.status  = ST_EMPTY;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_UNLINK;
                        end
                    end
                    CMD_REM:
                    begin
                        if (!stat.id_ok || !stat.queued)
                        begin
                            ctrl.respond = 1'b1;
                            ctrl.status  = ST_ABSENT;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_UNLINK;
                        end
                    end
                    CMD_NOP:
                    begin
                        ctrl.respond = 1'b1;
                        state_next   = S_IDLE;
                    end
                    default:
                    begin
                        ctrl.respond = 1'b1;
                        state_next   = S_IDLE;
                    end
                endcase
            end
            S_ENQ_LINK:
            begin
                ctrl.enq_tail = 1'b1;
                ctrl.respond  = 1'b1;
                state_next    = S_IDLE;
            end
            S_UNLINK:
            begin
                ctrl.unlink  = 1'b1;
                ctrl.respond = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### design/lbq_datapath.sv
// lbq_datapath: link memories, membership bits, head/tail/count and result register
// depends on lbq_pkg; commanded by lbq_ctrl
module lbq_datapath
    import lbq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lbq_req_t  request,
    input  lbq_ctrl_t ctrl,
    output lbq_stat_t stat,
    output lbq_rsp_t  result,
    output logic      done
);

    logic [LINK_W-1:0]      next_mem [NUM_BUFFERS];
    logic [LINK_W-1:0]      prev_mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] in_queue_reg;

    lbq_req_t          req_reg;
    logic [ADDR_W-1:0] target_reg;
    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] head_next;
    logic [LINK_W-1:0] tail_reg;
    logic [LINK_W-1:0] tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [LINK_W-1:0] rd_next_reg;
    logic [LINK_W-1:0] rd_prev_reg;
    lbq_rsp_t          rsp_reg;
    logic              done_reg;

    logic [ADDR_W-1:0] id_addr;
    logic [ADDR_W-1:0] sel_addr;
    logic              nw_en;
    logic [ADDR_W-1:0] nw_addr;
    logic [LINK_W-1:0] nw_data;
    logic              pw_en;
    logic [ADDR_W-1:0] pw_addr;
    logic [LINK_W-1:0] pw_data;
    logic              p_null;
    logic              n_null;
    logic              tail_null;

    assign id_addr   = ADDR_W'(req_reg.buf_id);
    assign sel_addr  = (req_reg.cmd == CMD_DEQ) ? head_reg[ADDR_W-1:0] : id_addr;
    assign p_null    = rd_prev_reg[LINK_W-1];
    assign n_null    = rd_next_reg[LINK_W-1];
    assign tail_null = tail_reg[LINK_W-1];

    assign stat.cmd    = req_reg.cmd;
    assign stat.id_ok  = (32'(req_reg.buf_id) < NUM_BUFFERS);
    assign stat.queued = in_queue_reg[sel_addr];
    assign stat.empty  = head_reg[LINK_W-1];

    // link memory write ports
    always_comb
    begin
        nw_en   = 1'b0;
        nw_addr = id_addr;
        nw_data = LINK_NULL;
        pw_en   = 1'b0;
        pw_addr = id_addr;
        pw_data = tail_reg;
        if (ctrl.enq_self)
        begin
            nw_en = 1'b1;
            pw_en = 1'b1;
        end
        else if (ctrl.enq_tail)
        begin
            nw_en   = !tail_null;
            nw_addr = tail_reg[ADDR_W-1:0];
            nw_data = LINK_W'(target_reg);
        end
        else if (ctrl.unlink)
        begin
            nw_en   = !p_null;
            nw_addr = rd_prev_reg[ADDR_W-1:0];
            nw_data = rd_next_reg;
            pw_en   = !n_null;
            pw_addr = rd_next_reg[ADDR_W-1:0];
            pw_data = rd_prev_reg;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.enq_tail)
        begin
            if (tail_null)
            begin
                head_next = LINK_W'(target_reg);
            end
            tail_next  = LINK_W'(target_reg);
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.unlink)
        begin
            if (p_null)
            begin
                head_next = rd_next_reg;
            end
            if (n_null)
            begin
                tail_next = rd_prev_reg;
            end
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (nw_en)
        begin
            next_mem[nw_addr] <= nw_data;
        end
        if (pw_en)
        begin
            prev_mem[pw_addr] <= pw_data;
        end
        rd_next_reg <= next_mem[sel_addr];
        rd_prev_reg <= prev_mem[sel_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            req_reg <= request;
        end
        if (ctrl.capture)
        begin
            target_reg <= sel_addr;
        end
        if (ctrl.respond)
        begin
            rsp_reg.status       <= ctrl.status;
            rsp_reg.out_id       <= (ctrl.unlink && req_reg.cmd == CMD_DEQ) ?
                                    ID_W'(target_reg) : '0;
            rsp_reg.queue_length <= QLEN_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= LINK_NULL;
            tail_reg     <= LINK_NULL;
            count_reg    <= '0;
            in_queue_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= ctrl.respond;
            if (ctrl.enq_tail)
            begin
                in_queue_reg[target_reg] <= 1'b1;
            end
            else if (ctrl.unlink)
            begin
                in_queue_reg[target_reg] <= 1'b0;
            end
        end
    end

    assign result = rsp_reg;
    assign done   = done_reg;

endmodule

### design/linked_buffer_queue.sv
// linked_buffer_queue: doubly linked queue of buffer ids with enqueue, dequeue and remove
// done is registered from S_CHECK for rejects and no-ops, else from S_ENQ_LINK or S_UNLINK
// a new request is taken only once the last is through: link memories are read, then written
// busy is high while a request is in flight; results cannot be stalled by the receiver
// reset: async active low, empties the queue; link memories are not cleared
// depends on lbq_pkg, lbq_ctrl, lbq_datapath
module linked_buffer_queue
    import lbq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  lbq_req_t request,
    output logic     busy,
    output logic     done,
    output lbq_rsp_t result
);

    lbq_ctrl_t ctrl;
    lbq_stat_t stat;

    lbq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    lbq_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctrl    (ctrl),
        .stat    (stat),
        .result  (result),
        .done    (done)
    );

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without request in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_busy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy && $past(busy) |=> !busy)
        else $error("request in flight longer than expected");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_EMPTY |->
        result.out_id == '0 && result.queue_length == '0)
        else $error("empty dequeue reported nonzero id or length");
`endif

endmodule

### tb/sv/tb_linked_buffer_queue.sv
// tb_linked_buffer_queue: self-checking bench for the linked buffer queue, directed then random
// requests; a shadow of the linked list predicts every result. depends on lbq_pkg and linked_buffer_queue
`timescale 1ns / 1ps

module tb_linked_buffer_queue
    import lbq_pkg::*;
();

    typedef struct {
        lbq_req_t rq;
        bit       hold;
    } plan_item_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    lbq_req_t request = '0;
    logic     busy;
    logic     done;
    lbq_rsp_t result;

    linked_buffer_queue i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    // shadow list state
    logic [LINK_W-1:0] next_of [NUM_BUFFERS];
    logic [LINK_W-1:0] prev_of [NUM_BUFFERS];
    bit                on_list [NUM_BUFFERS];
    logic [LINK_W-1:0] list_head = LINK_NULL;
    logic [LINK_W-1:0] list_tail = LINK_NULL;
    int                list_len = 0;

    plan_item_t request_backlog [$];
    lbq_rsp_t   pending_outcomes [$];
    int         mismatch_count = 0;

    // generation-time view of the queue order
    int gen_order [$];
    bit gen_on [NUM_BUFFERS];
    int planned = 0;

    function automatic void detach(logic [ADDR_W-1:0] id);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        p = prev_of[id];
        n = next_of[id];
        if (!p[ADDR_W])
            next_of[p[ADDR_W-1:0]] = n;
        else
            list_head = n;
        if (!n[ADDR_W])
            prev_of[n[ADDR_W-1:0]] = p;
        else
            list_tail = p;
        next_of[id] = LINK_NULL;
        prev_of[id] = LINK_NULL;
        on_list[id] = 1'b0;
        if (list_len > 0)
            list_len--;
    endfunction

    function automatic lbq_rsp_t apply_queue_op(lbq_req_t rq);
        lbq_rsp_t          rs;
        logic [ADDR_W-1:0] id;
        id = rq.buf_id[ADDR_W-1:0];
        rs.status = ST_OK;
        rs.out_id = '0;
        case (rq.cmd)
            CMD_ENQ:
            begin
                if (on_list[id])
                    rs.status = ST_DUP;
                else
                begin
                    next_of[id] = LINK_NULL;
                    prev_of[id] = list_tail;
                    if (!list_tail[ADDR_W])
                        next_of[list_tail[ADDR_W-1:0]] = {1'b0, id};
                    else
                        list_head = {1'b0, id};
                    list_tail = {1'b0, id};
                    on_list[id] = 1'b1;
                    list_len++;
                end
            end
            CMD_DEQ:
            begin
                if (list_head[ADDR_W] || list_len == 0)
                    rs.status = ST_EMPTY;
                else
                begin
                    rs.out_id = list_head[ADDR_W-1:0];
                    detach(list_head[ADDR_W-1:0]);
                end
            end
            CMD_REM:
            begin
                if (!on_list[id])
                    rs.status = ST_ABSENT;
                else
                    detach(id);
            end
            default:
            begin
            end
        endcase
        rs.queue_length = QLEN_W'(list_len);
        return rs;
    endfunction

    task automatic add_req(cmd_t c, int id, bit hold = 1'b0);
        plan_item_t it;
        it.rq.cmd = c;
        it.rq.buf_id = ID_W'(id);
        it.hold = hold;
        request_backlog.push_back(it);
        planned++;
        if (c == CMD_ENQ && !gen_on[id])
        begin
            gen_order.push_back(id);
            gen_on[id] = 1'b1;
        end
        else if (c == CMD_DEQ && gen_order.size() > 0)
            gen_on[gen_order.pop_front()] = 1'b0;
        else if (c == CMD_REM && gen_on[id])
        begin
            gen_on[id] = 1'b0;
            foreach (gen_order[k])
                if (gen_order[k] == id)
                begin
                    gen_order.delete(k);
                    break;
                end
        end
    endtask

    function automatic int free_id();
        int id;
        id = $urandom_range(0, NUM_BUFFERS - 1);
        if (gen_order.size() < NUM_BUFFERS)
            while (gen_on[id])
                id = $urandom_range(0, NUM_BUFFERS - 1);
        return id;
    endfunction

    function automatic int queued_id();
        if (gen_order.size() == 0)
            return $urandom_range(0, NUM_BUFFERS - 1);
        return gen_order[$urandom_range(0, gen_order.size() - 1)];
    endfunction

    task automatic report_mismatch(string what, lbq_rsp_t exp_rs, lbq_rsp_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected status %0d id %0d len %0d, got status %0d id %0d len %0d",
                     $realtime, what, exp_rs.status, exp_rs.out_id, exp_rs.queue_length,
                     got.status, got.out_id, got.queue_length);
    endtask

    // request driver
    int idle_left = 0;
    bit idle_on = 1'b1;

    always @(posedge clk)
    begin : drive_proc
        bit accepted;
        accepted = start && !busy;
        if (rst_n)
        begin
            if (accepted)
            begin
                pending_outcomes.push_back(apply_queue_op(request));
                void'(request_backlog.pop_front());
            end
            if (!start || accepted)
            begin
                if ($urandom_range(0, 39) == 0)
                    idle_on = !idle_on;
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (idle_on && request_backlog.size() > 60
                         && $urandom_range(0, 4) == 0)
                begin
                    idle_left = $urandom_range(1, 12) - 1;
                    start <= 1'b0;
                end
                else if (request_backlog.size() > 0
                         && !(request_backlog[0].hold && pending_outcomes.size() > 0))
                begin
                    start <= 1'b1;
                    request <= request_backlog[0].rq;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : check_proc
        lbq_rsp_t exp_rs;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected result", '0, result);
            else
            begin
                exp_rs = pending_outcomes.pop_front();
                if (result.status !== exp_rs.status || result.out_id !== exp_rs.out_id
                    || result.queue_length !== exp_rs.queue_length)
                    report_mismatch("result mismatch", exp_rs, result);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stim_proc
        int round;
        int n;
        int kind;
        foreach (on_list[k])
        begin
            on_list[k] = 1'b0;
            gen_on[k] = 1'b0;
        end

        // directed requests
        add_req(CMD_DEQ, 0);
        add_req(CMD_REM, 17);
        add_req(CMD_NOP, 63);
        add_req(CMD_ENQ, 0);
        add_req(CMD_ENQ, 63);
        add_req(CMD_ENQ, 0);
        add_req(CMD_ENQ, 21);
        add_req(CMD_ENQ, 42);
        add_req(CMD_REM, 63);
        add_req(CMD_REM, 42);
        add_req(CMD_REM, 5);
        add_req(CMD_NOP, 42);
        add_req(CMD_DEQ, 0);
        add_req(CMD_DEQ, 63);
        add_req(CMD_DEQ, 0);
        add_req(CMD_ENQ, 63);
        add_req(CMD_REM, 63);
        add_req(CMD_ENQ, 10);
        add_req(CMD_ENQ, 11);
        add_req(CMD_REM, 10);
        add_req(CMD_DEQ, 0);
        add_req(CMD_REM, 11);

        // random part
        round = 0;
        while (planned < 870)
        begin
            kind = (round < 2) ? 0 : $urandom_range(0, 9);
            case (kind)
                0, 1:
                begin
                    n = (round < 2 || $urandom_range(0, 2) == 0)
                        ? NUM_BUFFERS : $urandom_range(1, 20);
                    for (int k = 0; k < n && gen_order.size() < NUM_BUFFERS; k++)
                        add_req(CMD_ENQ, free_id(), k == 0 && round == 1);
                    add_req(CMD_NOP, $urandom_range(0, NUM_BUFFERS - 1));
                    add_req(CMD_ENQ, queued_id());
                end
                2:
                begin
                    while (gen_order.size() > 0)
                        if ($urandom_range(0, 2) == 0)
                            add_req(CMD_REM, queued_id());
                        else
                            add_req(CMD_DEQ, $urandom_range(0, NUM_BUFFERS - 1));
                    add_req(CMD_DEQ, $urandom_range(0, NUM_BUFFERS - 1));
                    add_req(CMD_REM, $urandom_range(0, NUM_BUFFERS - 1));
                end
                3:
                begin
                    repeat (8)
                        add_req(cmd_t'($urandom_range(0, 3)), $urandom_range(0, NUM_BUFFERS - 1));
                end
                default:
                begin
                    for (int k = 0; k < 20; k++)
                    begin
                        n = $urandom_range(0, 99);
                        if (n < 38)
                            add_req(CMD_ENQ, ($urandom_range(0, 9) == 0) ? queued_id() : free_id(),
                                    k == 0 && $urandom_range(0, 7) == 0);
                        else if (n < 63)
                            add_req(CMD_DEQ, $urandom_range(0, NUM_BUFFERS - 1));
                        else if (n < 95)
                            add_req(CMD_REM, ($urandom_range(0, 5) == 0)
                                    ? $urandom_range(0, NUM_BUFFERS - 1) : queued_id());
                        else
                            add_req(CMD_NOP, $urandom_range(0, NUM_BUFFERS - 1));
                    end
                end
            endcase
            round++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
design/lbq_pkg.sv
design/lbq_ctrl.sv
design/lbq_datapath.sv
design/linked_buffer_queue.sv
tb/sv/tb_linked_buffer_queue.sv
